// ===== rtl/rmrs_pkg.sv =====
// Shared constants and types for the running mean and Reynolds stress block.
`timescale 1ns / 1ps
package rmrs_pkg;
  localparam int unsigned POINTS_DEF     = 4096;
  localparam int unsigned COUNT_BITS_DEF = 24;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned MOMENT_W       = 48;
  localparam int unsigned NUM_MEANS      = 4;
  localparam int unsigned NUM_MOMENTS    = 6;
  localparam int unsigned NUM_CHANNELS   = NUM_MEANS + NUM_MOMENTS;
  localparam int unsigned CH_W           = 4;
  localparam int unsigned DIV_W          = 50;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MOMENT_W-1:0] moment_t;

  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;
endpackage

// ===== rtl/running_mean_reynolds_stress.sv =====
// Top level: per-point running means and Reynolds stresses over one memory.
//
//   channel | direction | handshake        | payload
//   in      | in        | in_valid/stall   | mode point vel_x vel_y vel_z pressure sweep_end
//   out     | out       | out_valid/stall  | avg_x..avg_pressure stress_xx..stress_yz
//
// An accumulate item holds the input through a memory read, then for each of the ten means a
// load, DIV_W quotient bits of the shared divider and a row update, then the write-back. An
// accumulate to a point outside the store ends after the memory read, with no write-back.
// A read item does the memory read, then the shared multiplier steps through the six stress
// terms, then loads the output. After reset a clearing pass zeroes all points before any item.
// A result held by output stall keeps a following read item before its multiply.
`timescale 1ns / 1ps
module running_mean_reynolds_stress #(
  parameter int unsigned POINTS     = rmrs_pkg::POINTS_DEF,
  parameter int unsigned COUNT_BITS = rmrs_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [11:0] point,
  input  logic signed [23:0] vel_x,
  input  logic signed [23:0] vel_y,
  input  logic signed [23:0] vel_z,
  input  logic signed [23:0] pressure,
  input  logic        sweep_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] avg_x,
  output logic signed [23:0] avg_y,
  output logic signed [23:0] avg_z,
  output logic signed [23:0] avg_pressure,
  output logic signed [47:0] stress_xx,
  output logic signed [47:0] stress_yy,
  output logic signed [47:0] stress_zz,
  output logic signed [47:0] stress_xy,
  output logic signed [47:0] stress_xz,
  output logic signed [47:0] stress_yz
);
  localparam int unsigned AW     = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int unsigned ROW_W  = rmrs_pkg::NUM_MEANS * rmrs_pkg::SAMPLE_W
                                 + rmrs_pkg::NUM_MOMENTS * rmrs_pkg::MOMENT_W;
  localparam int unsigned DW     = rmrs_pkg::DIV_W;
  localparam int unsigned DCNT_W = $clog2(DW + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic signed [rmrs_pkg::MOMENT_W-1:0] S48MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [rmrs_pkg::MOMENT_W-1:0] S48MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DIV, ST_MUL, ST_OUT, ST_WRITE
  } state_t;

  state_t state;
  logic [ROW_W-1:0] mem [POINTS];
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] row;
  logic [AW:0]  clr_addr;
  logic [AW-1:0] addr;
  logic [AW-1:0] rd_addr;
  logic          mode_q, send_q, pt_ok;
  logic signed [23:0] xs [4];
  logic [COUNT_BITS-1:0] sample_count;
  logic [3:0]  ch;
  logic [DCNT_W-1:0] dcnt;
  logic [DW-1:0] rem, quo;
  logic [DW-1:0] dvd_mag;
  logic          d_neg;
  logic signed [DW-1:0] cur_m, cur_d;
  logic signed [47:0] prod;
  logic [2:0] mstep;
  logic [2:0] mstep_w;
  logic signed [48:0] diff_w;

  // Row layout: four 24-bit means then six 48-bit moments.
  function automatic logic signed [47:0] get_ch(input logic [ROW_W-1:0] r, input logic [3:0] c);
    if (c < 4'd4) return 48'(signed'(r[c[1:0]*24 +: 24]));
    return r[96 + (c - 4'd4) * 48 +: 48];
  endfunction

  function automatic logic signed [47:0] sample_of(input logic [3:0] c,
      input logic signed [23:0] a, input logic signed [23:0] b,
      input logic signed [23:0] cc, input logic signed [23:0] p);
    unique case (c)
      4'd0: return 48'(a);
      4'd1: return 48'(b);
      4'd2: return 48'(cc);
      4'd3: return 48'(p);
      4'd4: return a * a;
      4'd5: return b * b;
      4'd6: return cc * cc;
      4'd7: return a * b;
      4'd8: return a * cc;
      default: return b * cc;
    endcase
  endfunction

  function automatic logic signed [47:0] sat(input logic signed [48:0] v);
    if (v > 49'(S48MAX)) return S48MAX;
    if (v < 49'(S48MIN)) return S48MIN;
    return v[47:0];
  endfunction

  logic signed [47:0] smp;
  logic [DW:0] trial;
  logic [DW-1:0] kdiv;
  logic signed [DW-1:0] fq, base;
  assign kdiv  = DW'(sample_count) + DW'(1);
  assign smp   = sample_of(ch, xs[0], xs[1], xs[2], xs[3]);
  assign cur_m = DW'(get_ch(row, ch));
  assign cur_d = DW'(smp) - cur_m;
  assign trial = {rem, dvd_mag[DW-1]} - {1'b0, kdiv};

  // Floor quotient from magnitude result, then truncate toward zero on the sum.
  always_comb begin
    if (d_neg) fq = (rem != '0) ? -signed'(quo) - DW'(1) : -signed'(quo);
    else       fq = signed'(quo);
    base = cur_m + fq;
    if (rem != '0 && base < 0) base = base + DW'(1);
  end

  logic signed [23:0] ma, mb;
  always_comb begin
    unique case (mstep)
      3'd0: begin ma = xs[0]; mb = xs[0]; end
      3'd1: begin ma = xs[1]; mb = xs[1]; end
      3'd2: begin ma = xs[2]; mb = xs[2]; end
      3'd3: begin ma = xs[0]; mb = xs[1]; end
      3'd4: begin ma = xs[0]; mb = xs[2]; end
      default: begin ma = xs[1]; mb = xs[2]; end
    endcase
  end

  always_comb diff_w = 49'(get_ch(row, 4'(mstep_w) + 4'd4)) - 49'(prod);

  assign in_stall = (state != ST_IDLE);

  // The read starts in the cycle an item is taken, so its row is ready in ST_READ.
  assign rd_addr = (state == ST_IDLE) ? AW'(point) : addr;

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (state == ST_CLEAR) mem[clr_addr[AW-1:0]] <= '0;
    else if (state == ST_WRITE) mem[addr] <= row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      sample_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AW+1)'(POINTS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            send_q <= sweep_end;
            pt_ok  <= (32'(point) < POINTS);
            addr   <= AW'(point);
            xs[0] <= vel_x; xs[1] <= vel_y; xs[2] <= vel_z; xs[3] <= pressure;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          row <= pt_ok ? rd_data : '0;
          if (!pt_ok && mode_q == rmrs_pkg::MODE_ACCUM) begin
            if (send_q && sample_count < CMAX) sample_count <= sample_count + 1'b1;
            state <= ST_IDLE;
          end else if (mode_q == rmrs_pkg::MODE_READ) begin
            // The stress registers are the output, so a waiting result keeps the item here.
            if (!(out_valid && out_stall)) begin
              mstep <= '0;
              state <= ST_MUL;
            end
          end else begin
            ch <= '0; dcnt <= '0;
            state <= ST_DIV;
          end
          if (mode_q == rmrs_pkg::MODE_READ) begin
            for (int i = 0; i < 4; i++) xs[i] <= pt_ok ? rd_data[i*24 +: 24] : '0;
          end
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            d_neg   <= cur_d[DW-1];
            dvd_mag <= cur_d[DW-1] ? DW'(-cur_d) : DW'(cur_d);
            rem <= '0; quo <= '0;
            dcnt <= dcnt + 1'b1;
          end else if (dcnt <= DCNT_W'(DW)) begin
            if (!trial[DW]) begin
              rem <= trial[DW-1:0]; quo <= {quo[DW-2:0], 1'b1};
            end else begin
              rem <= {rem[DW-2:0], dvd_mag[DW-1]}; quo <= {quo[DW-2:0], 1'b0};
            end
            dvd_mag <= {dvd_mag[DW-2:0], 1'b0};
            dcnt <= dcnt + 1'b1;
          end else begin
            if (ch < 4'd4) row[ch[1:0]*24 +: 24] <= base[23:0];
            else row[96 + (ch - 4'd4) * 48 +: 48] <= base[47:0];
            dcnt <= '0;
            if (ch == 4'(rmrs_pkg::NUM_CHANNELS - 1)) state <= ST_WRITE;
            else ch <= ch + 1'b1;
          end
        end
        ST_WRITE: begin
          if (send_q && sample_count < CMAX) sample_count <= sample_count + 1'b1;
          state <= ST_IDLE;
        end
        ST_MUL: begin
          // Product from the previous step is registered before the subtract.
          if (mstep != 3'd0) begin
            unique case (mstep_w)
              3'd0: stress_xx <= sat(diff_w);
              3'd1: stress_yy <= sat(diff_w);
              3'd2: stress_zz <= sat(diff_w);
              3'd3: stress_xy <= sat(diff_w);
              3'd4: stress_xz <= sat(diff_w);
              default: stress_yz <= sat(diff_w);
            endcase
          end
          prod <= ma * mb;
          mstep_w <= mstep;
          if (mstep == 3'd5) state <= ST_OUT;
          else mstep <= mstep + 1'b1;
        end
        ST_OUT: begin
          stress_yz <= sat(diff_w);
          avg_x <= xs[0]; avg_y <= xs[1]; avg_z <= xs[2]; avg_pressure <= xs[3];
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
      (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
      (sample_count == CMAX) |=> (sample_count == CMAX)) else $error("count left saturation");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV || state == ST_MUL) |=> $stable(sample_count))
      else $error("count moved mid item");
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the per-point running mean and Reynolds stress block.
`timescale 1ns / 1ps
module tb_top;
  localparam int NPTS      = 4096;
  localparam int CNT_BITS  = 24;
  localparam int HOT_PTS   = 16;
  localparam int N_RANDOM  = 1000;
  localparam int WD_LIMIT  = 40000;
  localparam longint S48_MAX = 64'sd140737488355327;
  localparam longint S48_MIN = -64'sd140737488355328;

  typedef struct {
    rmrs_pkg::mode_t   mode;
    logic [11:0]       point;
    rmrs_pkg::sample_t vx, vy, vz, pr;
    logic              sweep;
  } sample_item_t;

  typedef struct {
    rmrs_pkg::sample_t ax, ay, az, ap;
    rmrs_pkg::moment_t sxx, syy, szz, sxy, sxz, syz;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [11:0] point = '0;
  logic signed [23:0] vel_x = '0, vel_y = '0, vel_z = '0, pressure = '0;
  logic sweep_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [23:0] avg_x, avg_y, avg_z, avg_pressure;
  logic signed [47:0] stress_xx, stress_yy, stress_zz, stress_xy, stress_xz, stress_yz;

  running_mean_reynolds_stress uut (.*);

  always #5 clk = ~clk;

  sample_item_t pending_items[$];
  stats_t       expected_stats[$];
  int  phase = 0;
  bit  in_took = 1'b0;
  bit  failed = 1'b0;
  int  idle_cycles = 0;

  // Predictor state.
  longint unsigned n_samples;
  longint mean_x[NPTS], mean_y[NPTS], mean_z[NPTS], mean_p[NPTS];
  longint mom_xx[NPTS], mom_yy[NPTS], mom_zz[NPTS];
  longint mom_xy[NPTS], mom_xz[NPTS], mom_yz[NPTS];

  // Truncating division of (m*n + x)/(n+1), done without forming m*n.
  function automatic longint running_mean(longint m, longint x, longint unsigned n);
    longint k, d, q, r, b;
    k = longint'(n) + 1;
    d = x - m;
    q = d / k;
    r = d % k;
    if (r < 0) begin
      q -= 1;
      r += k;
    end
    b = m + q;
    if (b < 0 && r != 0) b += 1;
    return b;
  endfunction

  function automatic rmrs_pkg::moment_t clip48(longint v);
    if (v > S48_MAX) return rmrs_pkg::moment_t'(S48_MAX);
    if (v < S48_MIN) return rmrs_pkg::moment_t'(S48_MIN);
    return rmrs_pkg::moment_t'(v);
  endfunction

  task automatic enqueue_item(sample_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic predict_stats(sample_item_t it);
    longint x, y, z, p;
    int i;
    stats_t s;
    x = longint'(it.vx);
    y = longint'(it.vy);
    z = longint'(it.vz);
    p = longint'(it.pr);
    i = int'(it.point);
    if (it.mode == rmrs_pkg::MODE_ACCUM) begin
      mean_x[i] = running_mean(mean_x[i], x, n_samples);
      mean_y[i] = running_mean(mean_y[i], y, n_samples);
      mean_z[i] = running_mean(mean_z[i], z, n_samples);
      mean_p[i] = running_mean(mean_p[i], p, n_samples);
      mom_xx[i] = running_mean(mom_xx[i], x * x, n_samples);
      mom_yy[i] = running_mean(mom_yy[i], y * y, n_samples);
      mom_zz[i] = running_mean(mom_zz[i], z * z, n_samples);
      mom_xy[i] = running_mean(mom_xy[i], x * y, n_samples);
      mom_xz[i] = running_mean(mom_xz[i], x * z, n_samples);
      mom_yz[i] = running_mean(mom_yz[i], y * z, n_samples);
      if (it.sweep && n_samples < (64'd1 << CNT_BITS) - 1) n_samples++;
    end else begin
      s.ax  = rmrs_pkg::sample_t'(mean_x[i]);
      s.ay  = rmrs_pkg::sample_t'(mean_y[i]);
      s.az  = rmrs_pkg::sample_t'(mean_z[i]);
      s.ap  = rmrs_pkg::sample_t'(mean_p[i]);
      s.sxx = clip48(mom_xx[i] - mean_x[i] * mean_x[i]);
      s.syy = clip48(mom_yy[i] - mean_y[i] * mean_y[i]);
      s.szz = clip48(mom_zz[i] - mean_z[i] * mean_z[i]);
      s.sxy = clip48(mom_xy[i] - mean_x[i] * mean_y[i]);
      s.sxz = clip48(mom_xz[i] - mean_x[i] * mean_z[i]);
      s.syz = clip48(mom_yz[i] - mean_y[i] * mean_z[i]);
      expected_stats.insert(expected_stats.size(), s);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  function automatic rmrs_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return rmrs_pkg::sample_t'($urandom_range(0, 511)) - 24'sd256;
      default: return rmrs_pkg::sample_t'($urandom());
    endcase
  endfunction

  function automatic sample_item_t make_item(rmrs_pkg::mode_t md, int pt,
                                             rmrs_pkg::sample_t x, rmrs_pkg::sample_t y,
                                             rmrs_pkg::sample_t z, rmrs_pkg::sample_t p,
                                             bit se);
    sample_item_t it;
    it.mode = md; it.point = pt[11:0];
    it.vx = x; it.vy = y; it.vz = z; it.pr = p; it.sweep = se;
    return it;
  endfunction

  // Driver: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (pending_items.size() > 0 &&
          !((phase == 1 && $urandom_range(0, 99) < 73) ||
            (phase == 3 && $urandom_range(0, 99) < 18))) begin
        sample_item_t it;
        it = pending_items.pop_front();
        in_valid  <= 1'b1;
        mode      <= it.mode;
        point     <= it.point;
        vel_x     <= it.vx;
        vel_y     <= it.vy;
        vel_z     <= it.vz;
        pressure  <= it.pr;
        sweep_end <= it.sweep;
        phase     <= (N_RANDOM - pending_items.size()) * 4 / N_RANDOM;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (phase == 2 && $urandom_range(0, 99) < 73) ||
                 (phase == 3 && $urandom_range(0, 99) < 18);
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall)
        predict_stats(make_item(rmrs_pkg::mode_t'(mode), int'(point), vel_x, vel_y, vel_z,
                                pressure, sweep_end));
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          $error("result arrived with no read item outstanding");
          failed = 1'b1;
        end else begin
          stats_t e;
          e = expected_stats.pop_front();
          check_field("avg_x", e.ax, avg_x);
          check_field("avg_y", e.ay, avg_y);
          check_field("avg_z", e.az, avg_z);
          check_field("avg_pressure", e.ap, avg_pressure);
          check_field("stress_xx", e.sxx, stress_xx);
          check_field("stress_yy", e.syy, stress_yy);
          check_field("stress_zz", e.szz, stress_zz);
          check_field("stress_xy", e.sxy, stress_xy);
          check_field("stress_xz", e.sxz, stress_xz);
          check_field("stress_yz", e.syz, stress_yz);
        end
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int k, sweep_pos;
    n_samples = 0;
    for (k = 0; k < NPTS; k++) begin
      mean_x[k] = 0; mean_y[k] = 0; mean_z[k] = 0; mean_p[k] = 0;
      mom_xx[k] = 0; mom_yy[k] = 0; mom_zz[k] = 0;
      mom_xy[k] = 0; mom_xz[k] = 0; mom_yz[k] = 0;
    end

    // Directed: untouched points, field extremes, sweep end on a read, top point.
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 0, 0, 0, 0, 0, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 1, 24'sh7FFFFF, 24'sh7FFFFF,
                           24'sh7FFFFF, 24'sh7FFFFF, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 1, 0, 0, 0, 0, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 1, 24'sh800000, 24'sh800000,
                           24'sh800000, 24'sh800000, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 1, 0, 0, 0, 0, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 1, 24'sh7FFFFF, 24'sh800000,
                           24'sh000001, 24'shFFFFFF, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 1, 24'sh7FFFFF, 24'sh800000,
                           24'sh7FFFFF, 24'sh800000, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 4095, 24'sh800000, 24'sh7FFFFF,
                           24'shFFFFFF, 24'sh000001, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 4095, 0, 0, 0, 0, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 2, -24'sd3, 24'sd5, -24'sd7, 24'sd1, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, 2, 24'sd2, -24'sd4, 24'sd6, -24'sd1, 1'b1));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 2, 0, 0, 0, 0, 1'b0));
    enqueue_item(make_item(rmrs_pkg::MODE_READ, 3000, 0, 0, 0, 0, 1'b1));

    // Random: mostly whole sweeps over a few hot points with reads between them.
    sweep_pos = 0;
    for (k = 0; k < N_RANDOM; k++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        enqueue_item(make_item(rmrs_pkg::MODE_ACCUM, sweep_pos, rand_sample(), rand_sample(),
                               rand_sample(), rand_sample(), sweep_pos == HOT_PTS - 1));
        sweep_pos = (sweep_pos + 1) % HOT_PTS;
      end else if (r < 95) begin
        enqueue_item(make_item(rmrs_pkg::MODE_READ, $urandom_range(0, HOT_PTS - 1),
                               rand_sample(), rand_sample(), rand_sample(),
                               rand_sample(), $urandom_range(0, 1)));
      end else begin
        enqueue_item(make_item(rmrs_pkg::mode_t'($urandom_range(0, 1)),
                               $urandom_range(0, NPTS - 1), rand_sample(),
                               rand_sample(), rand_sample(), rand_sample(),
                               $urandom_range(0, 1)));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && !in_valid && expected_stats.size() == 0);
    repeat (600) @(posedge clk);
    if (!failed && expected_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rmrs_pkg.sv
rtl/running_mean_reynolds_stress.sv
tb/sv/tb_top.sv
